// File: rtl/core/mqttpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqttpr_pkg
// Shared types and constants for the publish receiver with keepalive ping.
// ----------------------------------------------------------------------------
package mqttpr_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOPIC_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [15:0] KEEPALIVE_RST     = 16'd60;
  localparam logic [15:0] TOPIC_LIMIT_RST   = 16'd100;
  localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd256;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_PING    = 3'd0;
  localparam logic [2:0] KIND_TOPIC   = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // packet constants
  localparam logic [3:0] PUBLISH_NIBBLE = 4'h3;
  localparam logic [7:0] PINGREQ_TYPE   = 8'hC0;
  localparam logic [7:0] PINGREQ_LEN    = 8'h00;

  // depth of the result queue
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] payload_length;
  } result_t;

  typedef struct packed {
    logic [15:0] keepalive_seconds;
    logic [15:0] topic_limit;
    logic [15:0] payload_limit;
  } cfg_t;

  // results of one item, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PAYLOAD
  } phase_t;

  function automatic result_t mk_result(logic [2:0] kind, logic [7:0] data,
                                        logic last, logic [15:0] plen);
    result_t r;
    r.out_kind       = kind;
    r.out_byte       = data;
    r.out_last       = last;
    r.payload_length = plen;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mqttpr_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqttpr_cfg
// Configuration registers: keepalive reload, topic and payload limits.
// ----------------------------------------------------------------------------
module mqttpr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mqttpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mqttpr_pkg::CFG_DATA_W-1:0] cfg_data,
  output mqttpr_pkg::cfg_t                     cfg
);
  import mqttpr_pkg::*;

  cfg_t cfg_reg;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.keepalive_seconds <= KEEPALIVE_RST;
      cfg_reg.topic_limit       <= TOPIC_LIMIT_RST;
      cfg_reg.payload_limit     <= PAYLOAD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEEPALIVE:     cfg_reg.keepalive_seconds <= cfg_data;
        CFG_TOPIC_LIMIT:   cfg_reg.topic_limit       <= cfg_data;
        CFG_PAYLOAD_LIMIT: cfg_reg.payload_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: rtl/core/mqttpr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqttpr_parser
// Input register and packet state machine; produces up to two results for
// each item in a single pass.
// ----------------------------------------------------------------------------
module mqttpr_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mqttpr_pkg::item_t  in_data,
  input  wire mqttpr_pkg::cfg_t   cfg,
  input  wire logic               room,
  output mqttpr_pkg::push_t       push
);
  import mqttpr_pkg::*;

  localparam int RlW   = 7 * MAX_LENGTH_BYTES;
  localparam int LbcW  = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int ShW   = $clog2(RlW) + 1;
  localparam int DiffW = ((RlW > 17) ? RlW : 17) + 1;

  // input register
  logic  in_reg_valid;
  item_t in_reg;
  logic  accept;
  logic  process;

  // packet state
  phase_t          phase, phase_next;
  logic [RlW-1:0]  remaining_length, remaining_length_next;
  logic [LbcW-1:0] length_byte_count, length_byte_count_next;
  logic [15:0]     topic_length, topic_length_next;
  logic [15:0]     byte_counter, byte_counter_next;
  logic [15:0]     payload_remaining, payload_remaining_next;
  logic [15:0]     seconds_left, seconds_left_next;

  // shared terms
  logic              is_tick;
  logic [7:0]        b;
  logic              ping_due;
  logic              len_over;
  logic [ShW-1:0]    shamt;
  logic [RlW-1:0]    len_add;
  logic [15:0]       tl_lo_val;
  logic [15:0]       tl_cur;
  logic              tl_bad;
  logic [15:0]       bc_inc;
  logic              topic_last;
  logic [DiffW-1:0]  diff;
  logic              pl_bad;
  logic              pl_zero;
  logic              pay_last;

  assign process  = in_reg_valid && room;
  assign in_stall = in_reg_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (process) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_data;
    end
  end

  // decode terms for the held item
  assign is_tick    = (in_reg.operation == OP_TICK);
  assign b          = in_reg.rx_byte;
  assign ping_due   = (seconds_left <= 16'd1);
  assign len_over   = (length_byte_count >= LbcW'(MAX_LENGTH_BYTES));
  assign shamt      = ShW'(length_byte_count) * ShW'(7);
  assign len_add    = RlW'(b[6:0]) << shamt;
  assign tl_lo_val  = {topic_length[15:8], b};
  assign tl_bad     = (tl_lo_val >= cfg.topic_limit);
  assign tl_cur     = (phase == PH_TLEN_LO) ? tl_lo_val : topic_length;
  assign bc_inc     = byte_counter + 16'd1;
  assign topic_last = (bc_inc >= topic_length);
  assign pay_last   = (payload_remaining == 16'd1);

  // payload length = remaining length - 2 - topic length
  assign diff    = DiffW'(remaining_length) - DiffW'(tl_cur) - DiffW'(2);
  assign pl_bad  = diff[DiffW-1] || (diff[DiffW-2:0] >= (DiffW-1)'(cfg.payload_limit));
  assign pl_zero = (diff == '0);

  // next state
  always_comb begin
    phase_next             = phase;
    remaining_length_next  = remaining_length;
    length_byte_count_next = length_byte_count;
    topic_length_next      = topic_length;
    byte_counter_next      = byte_counter;
    payload_remaining_next = payload_remaining;
    seconds_left_next      = seconds_left;
    if (process) begin
      if (is_tick) begin
        if (phase == PH_HUNT) begin
          seconds_left_next = ping_due ? cfg.keepalive_seconds : seconds_left - 16'd1;
        end
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (b[7:4] == PUBLISH_NIBBLE) begin
              phase_next             = PH_LEN;
              remaining_length_next  = '0;
              length_byte_count_next = '0;
            end
          end
          PH_LEN: begin
            if (len_over) begin
              phase_next        = PH_HUNT;
              seconds_left_next = cfg.keepalive_seconds;
            end else begin
              remaining_length_next  = remaining_length + len_add;
              length_byte_count_next = length_byte_count + LbcW'(1);
              if (!b[7]) begin
                phase_next = PH_TLEN_HI;
              end
            end
          end
          PH_TLEN_HI: begin
            topic_length_next = {b, 8'h00};
            phase_next        = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            topic_length_next = tl_lo_val;
            byte_counter_next = '0;
            if (tl_bad || (tl_lo_val == 16'd0 && (pl_bad || pl_zero))) begin
              phase_next        = PH_HUNT;
              seconds_left_next = cfg.keepalive_seconds;
            end else if (tl_lo_val == 16'd0) begin
              payload_remaining_next = diff[15:0];
              phase_next             = PH_PAYLOAD;
            end else begin
              phase_next = PH_TOPIC;
            end
          end
          PH_TOPIC: begin
            byte_counter_next = bc_inc;
            if (topic_last) begin
              if (pl_bad || pl_zero) begin
                phase_next        = PH_HUNT;
                seconds_left_next = cfg.keepalive_seconds;
              end else begin
                payload_remaining_next = diff[15:0];
                byte_counter_next      = '0;
                phase_next             = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            byte_counter_next      = bc_inc;
            payload_remaining_next = payload_remaining - 16'd1;
            if (pay_last) begin
              phase_next        = PH_HUNT;
              seconds_left_next = cfg.keepalive_seconds;
            end
          end
          default: begin
            phase_next        = PH_HUNT;
            seconds_left_next = cfg.keepalive_seconds;
          end
        endcase
      end
    end
  end

  // results of the held item
  always_comb begin
    push.count  = 2'd0;
    push.first  = '0;
    push.second = '0;
    if (process) begin
      if (is_tick) begin
        if (phase == PH_HUNT && ping_due) begin
          push.count  = 2'd2;
          push.first  = mk_result(KIND_PING, PINGREQ_TYPE, 1'b0, 16'd0);
          push.second = mk_result(KIND_PING, PINGREQ_LEN, 1'b1, 16'd0);
        end
      end else begin
        unique case (phase)
          PH_LEN: begin
            if (len_over) begin
              push.count = 2'd1;
              push.first = mk_result(KIND_ERROR, 8'h00, 1'b1, 16'd0);
            end
          end
          PH_TLEN_LO: begin
            if (tl_bad || (tl_lo_val == 16'd0 && pl_bad)) begin
              push.count = 2'd1;
              push.first = mk_result(KIND_ERROR, 8'h00, 1'b1, 16'd0);
            end else if (tl_lo_val == 16'd0 && pl_zero) begin
              push.count = 2'd1;
              push.first = mk_result(KIND_END, 8'h00, 1'b1, 16'd0);
            end
          end
          PH_TOPIC: begin
            push.count = 2'd1;
            push.first = mk_result(KIND_TOPIC, b, 1'b0, 16'd0);
            if (topic_last && pl_bad) begin
              push.count  = 2'd2;
              push.second = mk_result(KIND_ERROR, 8'h00, 1'b1, 16'd0);
            end else if (topic_last && pl_zero) begin
              push.count  = 2'd2;
              push.second = mk_result(KIND_END, 8'h00, 1'b1, 16'd0);
            end
          end
          PH_PAYLOAD: begin
            push.count = 2'd1;
            push.first = mk_result(KIND_PAYLOAD, b, 1'b0, 16'd0);
            if (pay_last) begin
              push.count  = 2'd2;
              push.second = mk_result(KIND_END, 8'h00, 1'b1, bc_inc);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      remaining_length  <= '0;
      length_byte_count <= '0;
      topic_length      <= '0;
      byte_counter      <= '0;
      payload_remaining <= '0;
      seconds_left      <= KEEPALIVE_RST;
    end else begin
      phase             <= phase_next;
      remaining_length  <= remaining_length_next;
      length_byte_count <= length_byte_count_next;
      topic_length      <= topic_length_next;
      byte_counter      <= byte_counter_next;
      payload_remaining <= payload_remaining_next;
      seconds_left      <= seconds_left_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mqttpr_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqttpr_out_queue
// Small queue: takes up to two results a cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module mqttpr_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mqttpr_pkg::push_t push,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mqttpr_pkg::result_t    out_data
);
  import mqttpr_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  result_t         entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, wr_ptr_next;
  logic [PtrW-1:0] rd_ptr, rd_ptr_next;
  logic [CntW-1:0] count, count_next;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // space for the worst case of two results
  assign room      = (count <= CntW'(QUEUE_DEPTH - 2));

  // pointer and fill arithmetic
  always_comb begin
    wr_ptr_next = wr_ptr + PtrW'(push.count);
    rd_ptr_next = rd_ptr + PtrW'(pop);
    count_next  = count + CntW'(push.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PtrW'(1)] <= push.second;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mqtt_publish_receiver_keepalive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_publish_receiver_keepalive
// Publish packet receiver with keepalive ping request generation.
// ----------------------------------------------------------------------------
// Each item (a received byte or a one-second idle tick) is taken into an
// input register and fully handled by the packet state machine once the
// result queue has room, so one item is accepted per clock unless the input
// stalls. An item gives zero, one or two results; they go into a four-entry
// result queue that hands out one result per clock unless the output stalls.
// The queue sets the sustained rate: one item per cycle while results drain
// as fast as they arrive; the held item waits, and the input stalls, when
// the queue holds more than two results (output stalled, or a ping,
// end-of-topic or end-of-message item adding a second result).
// Configuration writes take effect from the next item handled.
// ----------------------------------------------------------------------------
module mqtt_publish_receiver_keepalive #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mqttpr_pkg::item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mqttpr_pkg::result_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [mqttpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mqttpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mqttpr_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;

  // configuration registers
  mqttpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // packet state machine
  mqttpr_parser #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .room     (room),
    .push     (push)
  );

  // result queue
  mqttpr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
